/* hdl/tfls_pkg.sv */
// Package for the timed fan and lamp sequencer: transfer payload structs,
// phase and fan command codes, register indexes and register reset values.
// No dependencies.
`default_nettype none

package tfls_pkg;

    localparam int ELAPSED_W = 10;
    localparam int SPEED_W   = 7;
    localparam int LIMIT_W   = 16;
    localparam int PHASE_W   = 3;
    localparam int CMD_W     = 2;
    localparam int CYCLES_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_RAMP_UP   = 3'd1,
        PH_LAMP_ON   = 3'd2,
        PH_OFF_WAIT  = 3'd3,
        PH_RAMP_DOWN = 3'd4,
        PH_REST      = 3'd5
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_ESTOP = 2'd3
    } fan_cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_FAN_SPEED_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAMP_ON_MS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAMP_OFF_WAIT_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_TIMEOUT_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REST_MS          = 3'd4;

    localparam logic [SPEED_W-1:0] RST_FAN_SPEED_TARGET = 7'd30;
    localparam logic [LIMIT_W-1:0] RST_LAMP_ON_MS       = 16'd10000;
    localparam logic [LIMIT_W-1:0] RST_LAMP_OFF_WAIT_MS = 16'd5000;
    localparam logic [LIMIT_W-1:0] RST_RAMP_TIMEOUT_MS  = 16'd10000;
    localparam logic [LIMIT_W-1:0] RST_REST_MS          = 16'd2000;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ms;
        logic                 fan_ramping;
        logic                 fan_stopped;
        logic                 fan_start_accepted;
        logic                 fan_stop_accepted;
    } poll_t;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [CMD_W-1:0]    fan_command;
        logic                lamp_a_on;
        logic                lamp_manual_select;
        logic                ramp_timed_out;
        logic [CYCLES_W-1:0] cycles_started;
    } result_t;

endpackage

`default_nettype wire

/* hdl/timed_fan_lamp_sequencer.sv */
// Top level of the timed fan and lamp sequencer: poll register, phase logic,
// configuration registers and result register. Depends on tfls_pkg.
`default_nettype none

//  Channel  | Signals                                  | Direction
//  poll     | poll_valid, poll_ready, poll (poll_t)    | in
//  result   | result_valid, result_ready, result       | out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A poll passes through two registers: the poll register, then the result
// register, which takes its result once the result register is free to accept it.
// One poll can be taken every cycle; the result register's stall propagates
// back through the poll register. Configuration writes are always ready.
// Reset leaves the block idle with the timer and cycle count at zero.

module timed_fan_lamp_sequencer
    import tfls_pkg::*;
#(
    parameter int TIMER_BITS = 16,
    parameter int COUNT_BITS = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 poll_valid,
    output logic                      poll_ready,
    input  wire poll_t                poll,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int CMP_W = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [SPEED_W-1:0]    fan_speed_target_reg;
    logic [LIMIT_W-1:0]    lamp_on_ms_reg;
    logic [LIMIT_W-1:0]    lamp_off_wait_ms_reg;
    logic [LIMIT_W-1:0]    ramp_timeout_ms_reg;
    logic [LIMIT_W-1:0]    rest_ms_reg;

    logic                  poll_valid_reg;
    poll_t                 poll_reg;
    logic                  result_valid_reg;
    result_t               result_reg;
    result_t               result_next;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TIMER_BITS-1:0] phase_timer_reg;
    logic [TIMER_BITS-1:0] phase_timer_next;
    logic [COUNT_BITS-1:0] cycle_counter_reg;
    logic [COUNT_BITS-1:0] cycle_counter_next;
    logic                  lamp_level_reg;
    logic                  lamp_level_next;

    logic                  step;
    logic [TIMER_BITS:0]   timer_sum;
    logic [TIMER_BITS-1:0] timer_sat;
    logic [CMP_W-1:0]      timer_cmp;
    fan_cmd_t              cmd;
    logic                  manual;
    logic                  timed_out;

    assign step       = poll_valid_reg && (!result_valid_reg || result_ready);
    assign poll_ready = !poll_valid_reg || step;
    assign cfg_ready  = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        timer_sum = {1'b0, phase_timer_reg} + (TIMER_BITS + 1)'(poll_reg.elapsed_ms);
        timer_sat = timer_sum[TIMER_BITS] ? TIMER_MAX : timer_sum[TIMER_BITS-1:0];
        timer_cmp = CMP_W'(timer_sat);

        phase_next         = phase_reg;
        phase_timer_next   = timer_sat;
        cycle_counter_next = cycle_counter_reg;
        lamp_level_next    = lamp_level_reg;
        cmd                = CMD_NONE;
        manual             = 1'b0;
        timed_out          = 1'b0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                cycle_counter_next = cycle_counter_reg + COUNT_BITS'(1);
                cmd = CMD_START;
                if (poll_reg.fan_start_accepted)
                begin
                    phase_next = PH_RAMP_UP;
                end
            end
            PH_RAMP_UP:
            begin
                if (!poll_reg.fan_ramping)
                begin
                    lamp_level_next = 1'b1;
                    manual = 1'b1;
                    phase_next = PH_LAMP_ON;
                end
                else if (timer_cmp > CMP_W'(ramp_timeout_ms_reg))
                begin
                    timed_out = 1'b1;
                    phase_next = PH_LAMP_ON;
                end
            end
            PH_LAMP_ON:
            begin
                if (timer_cmp >= CMP_W'(lamp_on_ms_reg))
                begin
                    lamp_level_next = 1'b0;
                    phase_next = PH_OFF_WAIT;
                end
            end
            PH_OFF_WAIT:
            begin
                if (timer_cmp >= CMP_W'(lamp_off_wait_ms_reg))
                begin
                    if (poll_reg.fan_stop_accepted)
                    begin
                        cmd = CMD_STOP;
                        phase_next = PH_RAMP_DOWN;
                    end
                    else
                    begin
                        cmd = CMD_ESTOP;
                        phase_next = PH_REST;
                    end
                end
            end
            PH_RAMP_DOWN:
            begin
                if (!poll_reg.fan_ramping && poll_reg.fan_stopped)
                begin
                    phase_next = PH_REST;
                end
                else if (timer_cmp > CMP_W'(ramp_timeout_ms_reg))
                begin
                    cmd = CMD_ESTOP;
                    timed_out = 1'b1;
                    phase_next = PH_REST;
                end
            end
            PH_REST:
            begin
                if (timer_cmp >= CMP_W'(rest_ms_reg))
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (phase_next != phase_reg)
        begin
            phase_timer_next = '0;
        end

        result_next.phase              = phase_next;
        result_next.fan_command        = cmd;
        result_next.lamp_a_on          = lamp_level_next;
        result_next.lamp_manual_select = manual;
        result_next.ramp_timed_out     = timed_out;
        result_next.cycles_started     = CYCLES_W'(cycle_counter_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fan_speed_target_reg <= RST_FAN_SPEED_TARGET;
            lamp_on_ms_reg       <= RST_LAMP_ON_MS;
            lamp_off_wait_ms_reg <= RST_LAMP_OFF_WAIT_MS;
            ramp_timeout_ms_reg  <= RST_RAMP_TIMEOUT_MS;
            rest_ms_reg          <= RST_REST_MS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FAN_SPEED_TARGET: fan_speed_target_reg <= cfg_data[SPEED_W-1:0];
                REG_LAMP_ON_MS:       lamp_on_ms_reg       <= cfg_data;
                REG_LAMP_OFF_WAIT_MS: lamp_off_wait_ms_reg <= cfg_data;
                REG_RAMP_TIMEOUT_MS:  ramp_timeout_ms_reg  <= cfg_data;
                REG_REST_MS:          rest_ms_reg          <= cfg_data;
                default:              rest_ms_reg          <= rest_ms_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_valid_reg    <= 1'b0;
            result_valid_reg  <= 1'b0;
            phase_reg         <= PH_IDLE;
            phase_timer_reg   <= '0;
            cycle_counter_reg <= '0;
            lamp_level_reg    <= 1'b0;
        end
        else
        begin
            if (poll_ready)
            begin
                poll_valid_reg <= poll_valid;
            end
            if (step)
            begin
                result_valid_reg  <= 1'b1;
                phase_reg         <= phase_next;
                phase_timer_reg   <= phase_timer_next;
                cycle_counter_reg <= cycle_counter_next;
                lamp_level_reg    <= lamp_level_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (poll_valid && poll_ready)
        begin
            poll_reg <= poll;
        end
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    // The target speed is stored but drives no output; it steers no decision.
    logic speed_target_nonzero;
    assign speed_target_nonzero = |fan_speed_target_reg;

    a_lamp_only_in_lamp_phase: assert property (@(posedge clk) disable iff (!rst_n)
        lamp_level_reg |-> (phase_reg == PH_LAMP_ON))
        else $error("lamp is lit outside the lamp-on phase");

    a_manual_pulse_lights_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.lamp_manual_select)
            |-> (result_reg.lamp_a_on && (result_reg.phase == PH_LAMP_ON)))
        else $error("manual select pulse without the lamp turning on");

    a_rampdown_timeout_estop: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.ramp_timed_out && (result_reg.phase == PH_REST))
            |-> (result_reg.fan_command == CMD_ESTOP))
        else $error("ramp-down timeout without emergency stop");

    a_idle_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (phase_reg == PH_IDLE))
            |=> (cycle_counter_reg == COUNT_BITS'($past(cycle_counter_reg) + COUNT_BITS'(1))))
        else $error("idle step did not count a start attempt");

    a_state_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(phase_timer_reg) && $stable(phase_reg)))
        else $error("sequencer state moved without a step");

    a_target_defined: assert property (@(posedge clk) disable iff (!rst_n)
        speed_target_nonzero |-> (fan_speed_target_reg != '0))
        else $error("fan speed target register inconsistent");

endmodule

`default_nettype wire
